>>> rtl/pcpr_pkg.sv
// ============================================================================
// pcpr_pkg
// Shared types and constants for the pin command packet responder.
// ============================================================================
package pcpr_pkg;

    // Virtual analog pin store
    localparam int VPIN_COUNT = 64;
    localparam int VPIN_AW    = (VPIN_COUNT > 1) ? $clog2(VPIN_COUNT) : 1;
    localparam int VPIN_BASE  = 64;

    // Job queue between the framer and the responder
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_NODE_ID      = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINK_ENABLED = 1'd1;

    // Result slots of one packet, in emission order
    localparam int NUM_SLOTS = 5;
    localparam logic [2:0] SLOT_PIN = 3'd0;
    localparam logic [2:0] SLOT_B0  = 3'd1;
    localparam logic [2:0] SLOT_B1  = 3'd2;
    localparam logic [2:0] SLOT_B2  = 3'd3;
    localparam logic [2:0] SLOT_B3  = 3'd4;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_PIN     = 2'd1,
        KIND_CAPTURE = 2'd2
    } res_kind_t;

    // Job operations handed from the framer to the responder
    typedef enum logic [2:0] {
        OP_CAPTURE      = 3'd0,
        OP_PIN_WRITE    = 3'd1,
        OP_REPLY        = 3'd2,
        OP_ANALOG_READ  = 3'd3,
        OP_ANALOG_WRITE = 3'd4
    } job_op_t;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [63:0] digital_levels;
        logic [9:0]  analog_sample;
    } req_t;

    typedef struct packed {
        res_kind_t   kind;
        logic [7:0]  tx_byte;
        logic [5:0]  pin;
        logic        level;
        logic [31:0] captured_packet;
        logic        last;
    } res_t;

    typedef struct packed {
        job_op_t            op;
        logic [31:0]        bytes;   // byte 0 lowest; reply bytes or capture
        logic [5:0]         pin;
        logic               level;
        logic               virt;
        logic [VPIN_AW-1:0] vaddr;
        logic [9:0]         sample;
    } job_t;

    // 14-bit value to two 7-bit groups, end mark on the last group used.
    // Result: {hi, lo}.
    function automatic logic [15:0] encode_value(input logic [13:0] v);
        logic [7:0] lo;
        logic [7:0] hi;
        if (v > 14'h007F)
        begin
            lo = {1'b0, v[6:0]};
            hi = {1'b1, v[13:7]};
        end
        else
        begin
            lo = {1'b1, v[6:0]};
            hi = {1'b0, v[13:7]};
        end
        return {hi, lo};
    endfunction

    function automatic logic [13:0] decode_value(input logic [7:0] lo, input logic [7:0] hi);
        return {hi[6:0], lo[6:0]};
    endfunction

endpackage

>>> rtl/pcpr_front.sv
// ============================================================================
// pcpr_front
// Frames received bytes into packets and classifies each finished packet
// into a job for the responder when it is a capture or is for this node.
// ============================================================================
module pcpr_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  pcpr_pkg::req_t  req_data,
    input  logic [3:0]      node_id,
    input  logic            link_enabled,
    output logic            job_push,
    output pcpr_pkg::job_t  job
);

    logic [7:0] pkt_reg [4];
    logic [7:0] pkt_next [4];
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       end_byte;
    logic       take;
    logic [7:0] f0;
    logic [7:0] f1;
    logic [7:0] f2;
    logic [7:0] f3;
    logic [6:0] apin;
    logic       lv;

    assign take     = accept && link_enabled;
    assign end_byte = req_data.rx_byte[7];

    // Packet framing
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (2'(i) < idx_reg)
                pkt_next[i] = pkt_reg[i];
            else if (2'(i) == idx_reg)
                pkt_next[i] = end_byte ? {1'b0, req_data.rx_byte[6:0]} : req_data.rx_byte;
            else
                pkt_next[i] = end_byte ? 8'h00 : pkt_reg[i];
        end
        if (end_byte)
            idx_next = 2'd0;
        else if (idx_reg != 2'd3)
            idx_next = idx_reg + 2'd1;
        else
            idx_next = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                pkt_reg[i] <= 8'h00;
            idx_reg <= 2'd0;
        end
        else if (take)
        begin
            pkt_reg <= pkt_next;
            idx_reg <= idx_next;
        end
    end

    assign f0   = pkt_next[0];
    assign f1   = pkt_next[1];
    assign f2   = pkt_next[2];
    assign f3   = pkt_next[3];
    assign apin = f1[6:0];
    assign lv   = req_data.digital_levels[f1[5:0]];

    // Packet classification
    always_comb
    begin
        job_push   = 1'b0;
        job.op     = pcpr_pkg::OP_REPLY;
        job.bytes  = {f3, f2, f1, f0 | 8'h10};
        job.pin    = f1[5:0];
        job.level  = f1[6];
        job.virt   = (apin >= 7'(pcpr_pkg::VPIN_BASE))
                     && ((apin - 7'(pcpr_pkg::VPIN_BASE)) < 7'(pcpr_pkg::VPIN_COUNT));
        job.vaddr  = pcpr_pkg::VPIN_AW'(apin - 7'(pcpr_pkg::VPIN_BASE));
        job.sample = req_data.analog_sample;
        if (take && end_byte)
        begin
            if (f0[4])
            begin
                job_push  = 1'b1;
                job.op    = pcpr_pkg::OP_CAPTURE;
                job.bytes = {f3, f2, f1, f0};
            end
            else if (f0[3:0] == node_id)
            begin
                job_push = 1'b1;
                if (f0[6])
                begin
                    if (f0[5])
                    begin
                        job.op    = pcpr_pkg::OP_REPLY;
                        job.bytes = {f3, f2, 1'b1, lv, f1[5:0], f0 | 8'h10};
                    end
                    else
                    begin
                        job.op    = pcpr_pkg::OP_PIN_WRITE;
                        job.bytes = {f3, f2, f1 | 8'h80, f0 | 8'h10};
                    end
                end
                else if (f0[5])
                    job.op = pcpr_pkg::OP_ANALOG_READ;
                else
                    job.op = pcpr_pkg::OP_ANALOG_WRITE;
            end
        end
    end

endmodule

>>> rtl/pcpr_queue.sv
// ============================================================================
// pcpr_queue
// Short job queue between the framer and the responder.
// ============================================================================
module pcpr_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pcpr_pkg::job_t  push_data,
    input  logic            pop,
    output logic            not_empty,
    output logic            full,
    output pcpr_pkg::job_t  head
);

    pcpr_pkg::job_t                  entry_reg [pcpr_pkg::QUEUE_DEPTH];
    logic [pcpr_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [pcpr_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [pcpr_pkg::QUEUE_CW-1:0]   count_reg;

    assign not_empty = (count_reg != pcpr_pkg::QUEUE_CW'(0));
    assign full      = (count_reg == pcpr_pkg::QUEUE_CW'(pcpr_pkg::QUEUE_DEPTH));
    assign head      = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == pcpr_pkg::QUEUE_AW'(pcpr_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == pcpr_pkg::QUEUE_AW'(pcpr_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + pcpr_pkg::QUEUE_CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - pcpr_pkg::QUEUE_CW'(1);
        end
    end

`ifndef SYNTH
    // No push into a full queue, no pop from an empty one
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("job queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && !not_empty))
        else $error("job queue underflow");
    // Fill count stays within the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pcpr_pkg::QUEUE_CW'(pcpr_pkg::QUEUE_DEPTH))
        else $error("job queue count out of range");
`endif

endmodule

>>> rtl/pcpr_back.sv
// ============================================================================
// pcpr_back
// Carries out jobs: virtual pin store access and result sequencing.
// ============================================================================
module pcpr_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    input  pcpr_pkg::job_t  job,
    output logic            job_pop,
    output logic            res_valid,
    input  logic            res_stall,
    output pcpr_pkg::res_t  res_data
);

    logic [13:0]                 vmem [pcpr_pkg::VPIN_COUNT];
    logic [pcpr_pkg::VPIN_COUNT-1:0] vvld_reg;
    logic [13:0]                 rd_data_reg;
    logic                        rd_vld_reg;
    logic                        work_valid_reg;
    pcpr_pkg::job_t              work_reg;
    logic [2:0]                  step_reg;

    logic [13:0]                 avalue;
    logic [15:0]                 enc;
    logic [7:0]                  b2;
    logic [7:0]                  b3;
    logic                        is_capture;
    logic [pcpr_pkg::NUM_SLOTS-1:0] slot_vld;
    logic [2:0]                  next_slot;
    logic                        next_found;
    logic                        res_take;

    // Virtual pin store: write on analog write to a virtual pin, read at every pop
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            if (job.op == pcpr_pkg::OP_ANALOG_WRITE && job.virt)
                vmem[job.vaddr] <= pcpr_pkg::decode_value(job.bytes[23:16], job.bytes[31:24]);
            rd_data_reg <= vmem[job.vaddr];
        end
    end

    // Written flags; unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vvld_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else if (job_pop)
        begin
            if (job.op == pcpr_pkg::OP_ANALOG_WRITE && job.virt)
                vvld_reg[job.vaddr] <= 1'b1;
            rd_vld_reg <= vvld_reg[job.vaddr];
        end
    end

    // Reply bytes 2 and 3, replaced by the encoded value on analog read
    assign avalue = work_reg.virt ? (rd_vld_reg ? rd_data_reg : 14'd0)
                                  : {4'd0, work_reg.sample};
    assign enc    = pcpr_pkg::encode_value(avalue);
    assign b2     = (work_reg.op == pcpr_pkg::OP_ANALOG_READ) ? enc[7:0]  : work_reg.bytes[23:16];
    assign b3     = (work_reg.op == pcpr_pkg::OP_ANALOG_READ) ? enc[15:8] : work_reg.bytes[31:24];
    assign is_capture = (work_reg.op == pcpr_pkg::OP_CAPTURE);

    // Slot selection
    always_comb
    begin
        slot_vld[0] = (work_reg.op == pcpr_pkg::OP_PIN_WRITE);
        slot_vld[1] = 1'b1;
        slot_vld[2] = !is_capture;
        slot_vld[3] = !is_capture && (b2 != 8'h00);
        slot_vld[4] = !is_capture && (b3 != 8'h00);
        next_found  = 1'b0;
        next_slot   = step_reg;
        for (int i = 0; i < pcpr_pkg::NUM_SLOTS; i++)
        begin
            if (!next_found && 3'(i) > step_reg && slot_vld[i])
            begin
                next_found = 1'b1;
                next_slot  = 3'(i);
            end
        end
    end

    // Result fields for the current slot
    always_comb
    begin
        res_data.kind            = pcpr_pkg::KIND_TX;
        res_data.tx_byte         = 8'h00;
        res_data.pin             = 6'd0;
        res_data.level           = 1'b0;
        res_data.captured_packet = 32'd0;
        res_data.last            = !next_found;
        case (step_reg)
            pcpr_pkg::SLOT_PIN:
            begin
                res_data.kind  = pcpr_pkg::KIND_PIN;
                res_data.pin   = work_reg.pin;
                res_data.level = work_reg.level;
            end
            pcpr_pkg::SLOT_B0:
            begin
                if (is_capture)
                begin
                    res_data.kind            = pcpr_pkg::KIND_CAPTURE;
                    res_data.captured_packet = work_reg.bytes;
                end
                else
                    res_data.tx_byte = work_reg.bytes[7:0];
            end
            pcpr_pkg::SLOT_B1: res_data.tx_byte = work_reg.bytes[15:8];
            pcpr_pkg::SLOT_B2: res_data.tx_byte = b2;
            pcpr_pkg::SLOT_B3: res_data.tx_byte = b3;
            default:           res_data.tx_byte = 8'h00;
        endcase
    end

    assign res_valid = work_valid_reg;
    assign res_take  = work_valid_reg && !res_stall;
    assign job_pop   = job_valid && (!work_valid_reg || (res_take && !next_found));

    // Work register and slot step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            step_reg       <= pcpr_pkg::SLOT_B0;
        end
        else if (job_pop)
        begin
            work_valid_reg <= 1'b1;
            step_reg       <= (job.op == pcpr_pkg::OP_PIN_WRITE) ? pcpr_pkg::SLOT_PIN
                                                                 : pcpr_pkg::SLOT_B0;
        end
        else if (res_take)
        begin
            if (!next_found)
                work_valid_reg <= 1'b0;
            else
                step_reg <= next_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
            work_reg <= job;
    end

`ifndef SYNTH
    // A captured packet is always the only result of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.kind == pcpr_pkg::KIND_CAPTURE |-> res_data.last)
        else $error("capture result not last");
    // A pin write is always followed by reply bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.kind == pcpr_pkg::KIND_PIN |-> !res_data.last)
        else $error("pin write result marked last");
    // A stalled non-final result keeps the same job in work
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(step_reg))
        else $error("result sequence advanced under stall");
`endif

endmodule

>>> rtl/pin_command_packet_responder.sv
// ============================================================================
// pin_command_packet_responder
// Frames received link bytes into packets and answers pin commands.
// ============================================================================
// Usage:
//   req channel (req_valid/req_stall/req_data) takes one received byte per
//   request with the current digital levels and analog sample. A byte is
//   taken when req_valid is high and req_stall is low.
//   res channel (res_valid/res_stall/res_data) gives the results of an end
//   byte: pin write, reply bytes or a captured reply packet; last marks the
//   final result of that byte.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes node_id
//   (index 0) and link_enabled (index 1); cfg_ready is always high.
// Timing:
//   An end byte with results is classified on acceptance and queued; the
//   job goes from the job queue into the work register, and its results
//   follow one per cycle while res_stall is low, one to five per packet,
//   set by the result sequencer; a two-entry queue lets bytes keep arriving.
// Reset and stall:
//   Reset clears the packet buffer, the job queue and the virtual pin store
//   flags at once. When the receiver stalls, the current result holds and
//   req_stall rises once the job queue is full.
// ============================================================================
module pin_command_packet_responder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  pcpr_pkg::req_t                      req_data,
    output logic                                res_valid,
    input  logic                                res_stall,
    output pcpr_pkg::res_t                      res_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pcpr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [3:0]      node_id_reg;
    logic            link_enabled_reg;
    logic            accept;
    logic            job_push;
    pcpr_pkg::job_t  job_in;
    logic            job_pop;
    logic            q_not_empty;
    logic            q_full;
    pcpr_pkg::job_t  q_head;

    assign cfg_ready = 1'b1;
    assign req_stall = q_full;
    assign accept    = req_valid && !req_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg      <= 4'd0;
            link_enabled_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pcpr_pkg::CFG_NODE_ID:      node_id_reg      <= cfg_data[3:0];
                pcpr_pkg::CFG_LINK_ENABLED: link_enabled_reg <= cfg_data[0];
                default:                    node_id_reg      <= node_id_reg;
            endcase
        end
    end

    pcpr_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .req_data     (req_data),
        .node_id      (node_id_reg),
        .link_enabled (link_enabled_reg),
        .job_push     (job_push),
        .job          (job_in)
    );

    pcpr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .not_empty (q_not_empty),
        .full      (q_full),
        .head      (q_head)
    );

    pcpr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_not_empty),
        .job       (q_head),
        .job_pop   (job_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule
